[src/sfto_pkg.sv]
// Package for the scaled-font text line overlay.
// Item types, field widths, register indexes and the 5x7 capital font table.
// No dependencies.
package sfto_pkg;

  localparam int SCALE_W  = 4;
  localparam int TOP_W    = 9;
  localparam int LEN_W    = 7;
  localparam int COLOR_W  = 16;
  localparam int SLOT_W   = 6;
  localparam int CODE_W   = 8;
  localparam int X_W      = 9;
  localparam int Y_W      = 9;
  localparam int CELLW_W  = 7;
  localparam int SPAN_W   = LEN_W + CELLW_W;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int LINE_WIDTH_DEF = 360;
  localparam int MAX_CHARS_DEF  = 64;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int CELL_COLS  = 6;

  localparam logic [CODE_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CODE_W-1:0] CHAR_Z_UP = 8'h5A;
  localparam logic [CODE_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CODE_W-1:0] CHAR_Z_LO = 8'h7A;
  localparam logic [CODE_W-1:0] CASE_FOLD = 8'h20;

  localparam logic [SCALE_W-1:0] SCALE_RST = 4'd1;
  localparam logic [COLOR_W-1:0] COLOR_RST = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_LENGTH = 2'd2,
    CFG_COLOR  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [SLOT_W-1:0]  char_slot;
    logic [CODE_W-1:0]  char_code;
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [COLOR_W-1:0] under_color;
  } req_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               lit;
  } rsp_item_t;

  // Columns 0..4 from MSB down, bit 0 of each column = top glyph row.
  localparam logic [34:0] CAPS_FONT [26] = '{
    {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}, {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
    {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C},
    {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01},
    {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A}, {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
    {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01},
    {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
    {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F}, {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F},
    {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
    {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E}, {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46},
    {7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
    {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}, {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
    {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F}, {7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
    {7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, {7'h61, 7'h51, 7'h49, 7'h45, 7'h43}
  };

  // Dot column of a character code; blank for anything but a letter.
  function automatic logic [GLYPH_ROWS-1:0] font_column(
    input logic [CODE_W-1:0] code,
    input logic [COL_W-1:0]  col
  );
    logic [CODE_W-1:0] folded;
    logic [4:0]        idx;
    logic [34:0]       entry;
    logic [GLYPH_ROWS-1:0] bits;
    folded = code;
    if (code >= CHAR_A_LO && code <= CHAR_Z_LO) begin
      folded = code - CASE_FOLD;
    end
    idx   = 5'(folded - CHAR_A_UP);
    entry = '0;
    if (folded >= CHAR_A_UP && folded <= CHAR_Z_UP) begin
      entry = CAPS_FONT[idx];
    end
    unique case (col)
      3'd0:    bits = entry[34:28];
      3'd1:    bits = entry[27:21];
      3'd2:    bits = entry[20:14];
      3'd3:    bits = entry[13:7];
      3'd4:    bits = entry[6:0];
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

[src/sfto_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module sfto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/scaled_font_text_line_overlay.sv]
// Top level of the scaled-font text line overlay.
// Depends on sfto_pkg and sfto_ram.
//
// Takes one item per clock while results are taken and returns one result per
// item, in order. An item passes the input register, the window register, the
// restoring divide stages that split the column offset into a cell number and
// an offset in the cell (one quotient bit per stage), the store read register
// and the result register. The whole pipeline holds while a result waits on
// rsp_ready. Loads write the character store at the same stage where queries
// read it, so loads and queries take effect in the order they were accepted.
// Configuration takes effect for items accepted from the cycle after the write.
module scaled_font_text_line_overlay
  import sfto_pkg::*;
#(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int MAX_CHARS  = MAX_CHARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_item_t             req_item,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_item_t             rsp_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW      = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int NSTG    = AW;
  localparam int LENC_W  = $clog2(MAX_CHARS + 1);
  localparam int REM_W   = LENC_W + CELLW_W;
  localparam int LW_W    = $clog2(LINE_WIDTH + 1);
  localparam int DIFF_W  = ((LW_W > SPAN_W) ? LW_W : SPAN_W) + 1;
  localparam int REL_W   = ((DIFF_W > X_W) ? DIFF_W : X_W) + 2;
  localparam int CMP_W   = (REL_W > REM_W) ? REL_W : REM_W;

  typedef struct packed {
    req_kind_t          kind;
    logic               ok;
    logic [ROW_W-1:0]   row;
    logic [REM_W-1:0]   rem;
    logic [AW-1:0]      quo;
    logic [SLOT_W-1:0]  slot;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] under;
  } stg_t;

  typedef struct packed {
    req_kind_t          kind;
    logic               ok;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COLOR_W-1:0] under;
  } rd_stg_t;

  // configuration
  logic [SCALE_W-1:0] text_scale;
  logic [TOP_W-1:0]   text_top;
  logic [LEN_W-1:0]   text_length;
  logic [COLOR_W-1:0] text_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_scale  <= SCALE_RST;
      text_top    <= '0;
      text_length <= '0;
      text_color  <= COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SCALE:  text_scale  <= cfg_data[SCALE_W-1:0];
        CFG_TOP:    text_top    <= cfg_data[TOP_W-1:0];
        CFG_LENGTH: text_length <= cfg_data[LEN_W-1:0];
        CFG_COLOR:  text_color  <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // derived line geometry
  logic [CELLW_W-1:0] cell_w;
  logic [LENC_W-1:0]  len_clamp;
  logic [SPAN_W-1:0]  span;
  logic [REM_W-1:0]   lspan;

  assign cell_w    = CELLW_W'(text_scale) * CELLW_W'(CELL_COLS);
  assign len_clamp = (int'(text_length) > MAX_CHARS) ? LENC_W'(MAX_CHARS)
                                                      : LENC_W'(text_length);

  always_ff @(posedge clk) begin
    span  <= SPAN_W'(text_length) * SPAN_W'(cell_w);
    lspan <= REM_W'(len_clamp) * REM_W'(cell_w);
  end

  // pipeline control
  logic adv;
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  // input register
  logic      a_vld;
  req_item_t a_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= req_item;
    end
  end

  // window check, glyph row and offset into the line
  logic [Y_W-1:0]            yd;
  logic [CELLW_W-1:0]        ylim;
  logic                      y_in;
  logic [ROW_W-1:0]          row_c;
  logic signed [DIFF_W-1:0]  sdiff;
  logic signed [DIFF_W-1:0]  sdiff_r;
  logic signed [DIFF_W-1:0]  start;
  logic signed [REL_W-1:0]   rel;
  logic                      x_in;
  stg_t                      b_next;

  always_comb begin
    yd    = a_item.pixel_y - text_top;
    ylim  = CELLW_W'(text_scale) * CELLW_W'(GLYPH_ROWS);
    y_in  = (text_scale != '0) && (a_item.pixel_y >= text_top) && (yd < Y_W'(ylim));
    row_c = '0;
    for (int k = 1; k < GLYPH_ROWS; k++) begin
      if (yd >= Y_W'(CELLW_W'(k) * CELLW_W'(text_scale))) begin
        row_c = row_c + ROW_W'(1);
      end
    end

    sdiff   = $signed(DIFF_W'(LINE_WIDTH)) - $signed(DIFF_W'(span));
    sdiff_r = sdiff + $signed({{(DIFF_W-1){1'b0}}, sdiff[DIFF_W-1]});
    start   = sdiff_r >>> 1;
    rel     = $signed(REL_W'({1'b0, a_item.pixel_x})) - REL_W'(start);
    x_in    = (int'(a_item.pixel_x) < LINE_WIDTH) && !rel[REL_W-1]
              && (CMP_W'($unsigned(rel)) < CMP_W'(lspan));

    b_next.kind  = a_item.req_type;
    b_next.ok    = y_in && x_in;
    b_next.row   = row_c;
    b_next.rem   = REM_W'($unsigned(rel));
    b_next.quo   = '0;
    b_next.slot  = a_item.char_slot;
    b_next.code  = a_item.char_code;
    b_next.under = a_item.under_color;
  end

  // restoring divide by the cell width, one quotient bit per stage
  logic vld  [0:NSTG];
  stg_t pipe [0:NSTG];
  stg_t nxt  [1:NSTG];

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      logic [REM_W:0] dv;
      dv         = (REM_W+1)'(cell_w) << (AW - 1 - k);
      nxt[k+1]   = pipe[k];
      if ({1'b0, pipe[k].rem} >= dv) begin
        nxt[k+1].rem          = pipe[k].rem - dv[REM_W-1:0];
        nxt[k+1].quo[AW-1-k]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NSTG; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= a_vld;
      for (int k = 1; k <= NSTG; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= b_next;
      for (int k = 1; k <= NSTG; k++) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  // character store access and column within the cell
  stg_t              p;
  logic [COL_W-1:0]  col_c;
  logic              gap;
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [CODE_W-1:0] st_rdata;
  rd_stg_t           r_next;
  rd_stg_t           r;
  logic              r_vld;

  assign p = pipe[NSTG];

  always_comb begin
    col_c = '0;
    for (int k = 1; k < GLYPH_COLS; k++) begin
      if (p.rem >= REM_W'(CELLW_W'(k) * CELLW_W'(text_scale))) begin
        col_c = col_c + COL_W'(1);
      end
    end
    gap = p.rem >= REM_W'(CELLW_W'(GLYPH_COLS) * CELLW_W'(text_scale));

    r_next.kind  = p.kind;
    r_next.ok    = p.ok && !gap;
    r_next.row   = p.row;
    r_next.col   = col_c;
    r_next.under = p.under;
  end

  assign st_we    = adv && vld[NSTG] && (p.kind == REQ_LOAD)
                    && (int'(p.slot) < MAX_CHARS);
  assign st_waddr = AW'(p.slot);

  sfto_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_CHARS)
  ) u_char_store (
    .clk     (clk),
    .we      (st_we),
    .wr_addr (st_waddr),
    .wr_data (p.code),
    .rd_en   (adv),
    .rd_addr (p.quo),
    .rd_data (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (adv) begin
      r_vld <= vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r <= r_next;
    end
  end

  // font lookup and result register
  logic [GLYPH_ROWS:0] dots;
  logic                lit_c;
  rsp_item_t           rsp_next;

  always_comb begin
    dots  = {1'b0, font_column(st_rdata, r.col)};
    lit_c = (r.kind == REQ_PIXEL) && r.ok && dots[r.row];
    rsp_next.lit = lit_c;
    if (r.kind == REQ_LOAD) begin
      rsp_next.pixel_color = '0;
    end else if (lit_c) begin
      rsp_next.pixel_color = text_color;
    end else begin
      rsp_next.pixel_color = r.under;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_item <= rsp_next;
    end
  end

endmodule
